// ----- sv/qdtm_pkg.sv -----
package qdtm_pkg;

    // Fixed field widths of the block's ports.
    localparam int VAL_W   = 32;
    localparam int CAP_W   = 5;
    localparam int STAT_W  = 3;
    localparam int CNT_W   = 5;

    // Built depth of the entry store and the capacity value after reset.
    localparam int DEPTH_DEF   = 16;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // Values of the action input.
    localparam logic ACT_APPEND = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_APPENDED = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_REMOVED  = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

endpackage

// ----- sv/qdtm_ram.sv -----
module qdtm_ram #(
    parameter int DEPTH = qdtm_pkg::DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [qdtm_pkg::VAL_W-1:0]  wdata,
    input  logic [AW-1:0]               raddr,
    output logic [qdtm_pkg::VAL_W-1:0]  rdata
);

    // Entry storage; contents are undefined until written.
    logic [qdtm_pkg::VAL_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/queue_dequeue_through_match.sv -----
// Results: an append, a full append or a dequeue on an empty queue shows its result
// in the cycle after the start transaction. A dequeue compares entries from the oldest
// on and reports on the first match, removing that entry and all older ones, or once
// the newest entry misses. Busy is held through the scan, so no new command is taken
// until it ends; the scan steps through the single read port of the entry memory. The
// receiver cannot stall. Reset empties the queue and sets the capacity register to 16.
module queue_dequeue_through_match #(
    parameter int DEPTH = qdtm_pkg::DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,

    // Configuration write port for the capacity register.
    input  logic                               cfg_we,
    input  logic [qdtm_pkg::CAP_W-1:0]         cfg_wdata,

    // Command side.
    input  logic                               start,
    output logic                               busy,
    input  logic                               action,
    input  logic signed [qdtm_pkg::VAL_W-1:0]  value,

    // Result side, one cycle per transaction.
    output logic                               done,
    output logic [qdtm_pkg::STAT_W-1:0]        status,
    output logic [qdtm_pkg::CNT_W-1:0]         removed_count,
    output logic [qdtm_pkg::CNT_W-1:0]         occupancy
);

    // AW indexes the memory; CW holds a count from zero up to DEPTH.
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > qdtm_pkg::CAP_W) ? CW : qdtm_pkg::CAP_W;
    localparam int PW = CW + 1;

    // The queue is a circular buffer: head_reg points at the oldest entry and
    // count_reg gives how many entries are held from there on. Removing entries through a
    // match only advances the head, so no entry ever has to move.
    qdtm_pkg::state_t                  state_reg,    state_next;
    logic [AW-1:0]                     head_reg,     head_next;
    logic [CW-1:0]                     count_reg,    count_next;
    logic [qdtm_pkg::CAP_W-1:0]        cap_reg;
    logic [qdtm_pkg::VAL_W-1:0]        value_reg,    value_next;

    // Scan sequencer: scan_idx_reg is the next offset to read, and the
    // cmp_* registers describe the entry whose data arrives this cycle.
    logic [CW-1:0]                     scan_idx_reg, scan_idx_next;
    logic [CW-1:0]                     cmp_idx_reg,  cmp_idx_next;
    logic                              cmp_valid_reg, cmp_valid_next;

    // Result registers.
    logic                              done_reg,     done_next;
    qdtm_pkg::status_t                 status_reg,   status_next;
    logic [qdtm_pkg::CNT_W-1:0]        removed_reg,  removed_next;
    logic [qdtm_pkg::CNT_W-1:0]        occ_reg,      occ_next;

    // Memory interface.
    logic                              mem_we;
    logic [AW-1:0]                     mem_waddr;
    logic [AW-1:0]                     mem_raddr;
    logic [qdtm_pkg::VAL_W-1:0]        mem_rdata;

    logic                              accept;
    logic                              is_full;
    logic [CW-1:0]                     remove_n;

    // Adds an offset to a buffer position, wrapping at DEPTH. The sum of the
    // operands stays below twice DEPTH, so one compare and subtract is enough.
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [PW-1:0] sum;
        sum = PW'(base) + PW'(off);
        if (sum >= PW'(DEPTH))
        begin
            sum = sum - PW'(DEPTH);
        end
        return AW'(sum);
    endfunction

    qdtm_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (value),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign accept    = start && !busy;
    assign busy      = (state_reg != qdtm_pkg::S_IDLE);

    // The effective capacity is the smaller of the register and DEPTH, so the
    // queue is full when either bound has been reached.
    assign is_full   = (EW'(count_reg) >= EW'(cap_reg)) || (count_reg == CW'(DEPTH));

    // Appends go to the slot just past the newest entry.
    assign mem_waddr = wrap_add(head_reg, count_reg);
    assign mem_raddr = wrap_add(head_reg, scan_idx_reg);

    // Entries removed on a match: the matched entry and all older ones.
    assign remove_n  = cmp_idx_reg + CW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= qdtm_pkg::S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            cap_reg       <= qdtm_pkg::CAP_RESET;
            scan_idx_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            scan_idx_reg  <= scan_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            done_reg      <= done_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        value_reg   <= value_next;
        cmp_idx_reg <= cmp_idx_next;
        status_reg  <= status_next;
        removed_reg <= removed_next;
        occ_reg     <= occ_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        value_next     = value_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        cmp_valid_next = 1'b0;
        done_next      = 1'b0;
        status_next    = status_reg;
        removed_next   = removed_reg;
        occ_next       = occ_reg;
        mem_we         = 1'b0;

        unique case (state_reg)
            qdtm_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    value_next   = value;
                    removed_next = '0;
                    if (action == qdtm_pkg::ACT_APPEND)
                    begin
                        done_next = 1'b1;
                        if (is_full)
                        begin
                            status_next = qdtm_pkg::ST_FULL;
                            occ_next    = qdtm_pkg::CNT_W'(count_reg);
                        end
                        else
                        begin
                            mem_we      = 1'b1;
                            count_next  = count_reg + CW'(1);
                            status_next = qdtm_pkg::ST_APPENDED;
                            occ_next    = qdtm_pkg::CNT_W'(count_next);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        done_next   = 1'b1;
                        status_next = qdtm_pkg::ST_EMPTY;
                        occ_next    = '0;
                    end
                    else
                    begin
                        state_next    = qdtm_pkg::S_SCAN;
                        scan_idx_next = '0;
                    end
                end
            end

            qdtm_pkg::S_SCAN:
            begin
                // Keep one read in flight ahead of the compare.
                if (scan_idx_reg < count_reg)
                begin
                    scan_idx_next  = scan_idx_reg + CW'(1);
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_idx_reg;
                end

                if (cmp_valid_reg)
                begin
                    if (mem_rdata == value_reg)
                    begin
                        head_next      = wrap_add(head_reg, remove_n);
                        count_next     = count_reg - remove_n;
                        status_next    = qdtm_pkg::ST_REMOVED;
                        removed_next   = qdtm_pkg::CNT_W'(remove_n);
                        occ_next       = qdtm_pkg::CNT_W'(count_next);
                        done_next      = 1'b1;
                        cmp_valid_next = 1'b0;
                        state_next     = qdtm_pkg::S_IDLE;
                    end
                    else if (cmp_idx_reg == count_reg - CW'(1))
                    begin
                        status_next    = qdtm_pkg::ST_NOTFOUND;
                        removed_next   = '0;
                        occ_next       = qdtm_pkg::CNT_W'(count_reg);
                        done_next      = 1'b1;
                        cmp_valid_next = 1'b0;
                        state_next     = qdtm_pkg::S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = qdtm_pkg::S_IDLE;
            end
        endcase
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign removed_count = removed_reg;
    assign occupancy     = occ_reg;

    // The queue never holds more than its built depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count exceeds the built depth");

    // Leaving the scan always produces a result transaction.
    a_scan_ends_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("scan finished without a result");

    // A dequeue on a non-empty queue enters the scan.
    a_dequeue_scans: assert property (@(posedge clk) disable iff (!rst_n)
        accept && action == qdtm_pkg::ACT_REMOVE && count_reg != '0 |=> busy)
        else $error("dequeue did not start a scan");

    // The scan only compares entries that are held.
    a_cmp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_valid_reg |-> cmp_idx_reg < count_reg)
        else $error("scan compared an entry beyond the occupancy");

    // A successful append grows the queue by exactly one entry.
    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == qdtm_pkg::ST_APPENDED |-> count_reg == $past(count_reg) + CW'(1))
        else $error("append did not add one entry");

endmodule

// ----- tb/sv/qdtm_result_checker.sv -----
// Watches the command, configuration and result channels of the queue.
// Every accepted command transaction is run through a private copy of the
// queue, and each result strobe is compared with the oldest prediction.
module qdtm_result_checker
    import qdtm_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CAP_W-1:0]         cfg_wdata,
    input  logic                     start,
    input  logic                     busy,
    input  logic                     action,
    input  logic signed [VAL_W-1:0]  value,
    input  logic                     done,
    input  logic [STAT_W-1:0]        status,
    input  logic [CNT_W-1:0]         removed_count,
    input  logic [CNT_W-1:0]         occupancy,
    output int                       pending,
    output int                       fail_count
);

    typedef struct packed {
        status_t          st;
        logic [CNT_W-1:0] removed;
        logic [CNT_W-1:0] occ;
    } queue_result_t;

    // Private copy of the queue, oldest entry at index 0.
    logic signed [VAL_W-1:0] model_entries[$];
    logic [CAP_W-1:0]        model_cap = CAP_RESET;
    queue_result_t           awaited_results[$];
    queue_result_t           oldest;
    int                      outstanding = 0;
    int                      err_total = 0;

    assign pending    = outstanding;
    assign fail_count = err_total;

    // Applies one command to the private queue and returns what the block must answer.
    function automatic queue_result_t predict_queue_op(input logic act,
                                                       input logic signed [VAL_W-1:0] v);
        queue_result_t r;
        int            limit;
        int            hit;
        r.removed = '0;
        limit = (int'(model_cap) > DEPTH) ? DEPTH : int'(model_cap);
        if (act == ACT_APPEND) begin
            if (model_entries.size() >= limit) begin
                r.st = ST_FULL;
            end
            else begin
                model_entries.push_back(v);
                r.st = ST_APPENDED;
            end
        end
        else if (model_entries.size() == 0) begin
            r.st = ST_EMPTY;
        end
        else begin
            hit = -1;
            for (int i = 0; i < model_entries.size(); i++)
            begin
                if (hit < 0 && model_entries[i] == v)
                    hit = i;
            end
            if (hit < 0) begin
                r.st = ST_NOTFOUND;
            end
            else begin
                r.st      = ST_REMOVED;
                r.removed = CNT_W'(hit + 1);
                repeat (hit + 1) void'(model_entries.pop_front());
            end
        end
        r.occ = CNT_W'(model_entries.size());
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            model_entries.delete();
            awaited_results.delete();
            model_cap   = CAP_RESET;
            outstanding <= 0;
        end
        else begin
            // A result belongs to an earlier command, so it is checked before
            // a command accepted at this same edge is queued.
            if (done) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t ERROR unexpected result: expected none, actual status %0d",
                             $time, status);
                    err_total++;
                end
                else begin
                    oldest = awaited_results.pop_front();
                    if (status !== oldest.st) begin
                        $display("%0t ERROR status: expected %0d, actual %0d",
                                 $time, oldest.st, status);
                        err_total++;
                    end
                    if (removed_count !== oldest.removed) begin
                        $display("%0t ERROR removed_count: expected %0d, actual %0d",
                                 $time, oldest.removed, removed_count);
                        err_total++;
                    end
                    if (occupancy !== oldest.occ) begin
                        $display("%0t ERROR occupancy: expected %0d, actual %0d",
                                 $time, oldest.occ, occupancy);
                        err_total++;
                    end
                end
            end
            if (cfg_we)
                model_cap = cfg_wdata;
            if (start && !busy)
                awaited_results.push_back(predict_queue_op(action, value));
            outstanding <= awaited_results.size();
        end
    end

endmodule

// ----- tb/sv/tb_queue_dequeue_through_match.sv -----
// Top of the queue testbench. It only generates stimulus and gives the verdict;
// prediction and comparison live in the checker instantiated beside the block.
module tb_queue_dequeue_through_match;
    import qdtm_pkg::*;

    localparam int TB_DEPTH     = DEPTH_DEF;
    localparam int RANDOM_ITEMS = 900;
    localparam int POOL_SIZE    = 8;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    cfg_we    = 1'b0;
    logic [CAP_W-1:0]        cfg_wdata = '0;
    logic                    start     = 1'b0;
    logic                    action    = ACT_APPEND;
    logic signed [VAL_W-1:0] value     = '0;

    logic                    busy;
    logic                    done;
    logic [STAT_W-1:0]       status;
    logic [CNT_W-1:0]        removed_count;
    logic [CNT_W-1:0]        occupancy;

    int                      pending;
    int                      fail_count;

    // Items left in the current burst of back-to-back commands.
    int                      burst_left;

    // A small pool of values shared by appends and dequeues, so that most
    // dequeues find a match somewhere in the queue and duplicates are common.
    logic signed [VAL_W-1:0] val_pool[POOL_SIZE];

    always #6 clk = ~clk;

    queue_dequeue_through_match #(
        .DEPTH(TB_DEPTH)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .value        (value),
        .done         (done),
        .status       (status),
        .removed_count(removed_count),
        .occupancy    (occupancy)
    );

    qdtm_result_checker #(
        .DEPTH(TB_DEPTH)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .value        (value),
        .done         (done),
        .status       (status),
        .removed_count(removed_count),
        .occupancy    (occupancy),
        .pending      (pending),
        .fail_count   (fail_count)
    );

    // Offers one command and holds it until the block takes it. The busy value
    // seen right after the edge is the one the block saw at that edge, so the
    // loop ends exactly at the accepting edge. When a burst runs out, start is
    // dropped at that edge and the sender stays quiet for a random gap; within
    // a burst start simply stays high for the next transaction.
    task automatic push_cmd(input logic act, input logic signed [VAL_W-1:0] v);
        int gap;
        start  <= 1'b1;
        action <= act;
        value  <= v;
        do @(posedge clk); while (busy);
        burst_left--;
        if (burst_left <= 0) begin
            start <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
    endtask

    // The capacity register is only written with the block idle: start low,
    // every predicted result already seen and busy released.
    task automatic settle_and_set_cap(input logic [CAP_W-1:0] cap);
        start <= 1'b0;
        do @(posedge clk); while (pending != 0 || busy);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Fills the value pool with a mix of the field extremes and random words.
    task automatic refresh_pool();
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            case ($urandom_range(0, 9))
                0:       val_pool[i] = 32'h8000_0000;
                1:       val_pool[i] = 32'h7FFF_FFFF;
                2:       val_pool[i] = 32'h0000_0000;
                3:       val_pool[i] = 32'hFFFF_FFFF;
                default: val_pool[i] = $urandom;
            endcase
        end
    endtask

    // Most values come from the pool; the rest are arbitrary words that will
    // almost never match anything and so exercise the full-length miss scan.
    function automatic logic signed [VAL_W-1:0] pick_value();
        if ($urandom_range(0, 99) < 85)
            return val_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    initial
    begin : stimulus
        logic [CAP_W-1:0] phase_cap;
        logic             act;
        int               append_pct;
        int               phase_len;
        int               random_done;
        int               phase;

        burst_left = $urandom_range(1, 40);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, starting at the reset capacity of 16.
        // A dequeue on an empty queue reports empty and changes nothing.
        push_cmd(ACT_REMOVE, 32'sd0);
        // The extremes of the value field and alternating bit patterns.
        push_cmd(ACT_APPEND, 32'h8000_0000);
        push_cmd(ACT_APPEND, 32'h7FFF_FFFF);
        push_cmd(ACT_APPEND, 32'h0000_0000);
        push_cmd(ACT_APPEND, 32'hFFFF_FFFF);
        push_cmd(ACT_APPEND, 32'h5555_5555);
        push_cmd(ACT_APPEND, 32'hAAAA_AAAA);
        // A miss scans every entry and removes nothing.
        push_cmd(ACT_REMOVE, 32'sd42);
        // A hit on the second entry removes it and the oldest one.
        push_cmd(ACT_REMOVE, 32'h7FFF_FFFF);
        // A hit on the newest entry drains the whole queue.
        push_cmd(ACT_REMOVE, 32'hAAAA_AAAA);
        // With duplicates only the oldest equal entry is the stopping point.
        push_cmd(ACT_APPEND, 32'sd5);
        push_cmd(ACT_APPEND, 32'sd5);
        push_cmd(ACT_REMOVE, 32'sd5);
        // A capacity of zero makes every append report full, while a dequeue
        // still works on the entry left over.
        settle_and_set_cap(CAP_W'(0));
        push_cmd(ACT_APPEND, 32'sd9);
        push_cmd(ACT_REMOVE, 32'sd5);
        // Capacity lowered below the occupancy: appends are refused, but a
        // dequeue through the newest entry still removes all three.
        settle_and_set_cap(CAP_W'(16));
        push_cmd(ACT_APPEND, 32'sd11);
        push_cmd(ACT_APPEND, 32'sd22);
        push_cmd(ACT_APPEND, 32'sd33);
        settle_and_set_cap(CAP_W'(1));
        push_cmd(ACT_APPEND, 32'sd44);
        push_cmd(ACT_REMOVE, 32'sd33);

        // Random part in phases. Each phase picks a capacity, a fresh value
        // pool and a mix of appends and dequeues; append-heavy phases fill the
        // queue to its limit, dequeue-heavy ones keep it near empty. The queue
        // is not drained between phases, so a smaller capacity often lands
        // below the current occupancy. The first phases hit the extremes of
        // the register, including values that saturate at the built depth.
        random_done = 0;
        phase       = 0;
        while (random_done < RANDOM_ITEMS)
        begin
            case (phase)
                0:       phase_cap = CAP_W'(16);
                1:       phase_cap = CAP_W'(31);
                2:       phase_cap = CAP_W'(1);
                3:       phase_cap = CAP_W'(0);
                4:       phase_cap = CAP_W'(17);
                default: phase_cap = CAP_W'($urandom_range(0, 31));
            endcase
            settle_and_set_cap(phase_cap);
            refresh_pool();
            append_pct = $urandom_range(30, 90);
            phase_len  = $urandom_range(40, 100);
            repeat (phase_len)
            begin
                act = ($urandom_range(0, 99) < append_pct) ? ACT_APPEND : ACT_REMOVE;
                push_cmd(act, pick_value());
                random_done++;
            end
            phase++;
        end

        // Let every outstanding result arrive, then watch a little longer than
        // the longest scan so that a stray strobe would still be caught.
        start <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (TB_DEPTH + 4) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin : watchdog
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
